// ----- hw/rtl/can_signal_pack_unpack_unit_assert.svh -----
// Assertion macros used by the checker file of the signal packing unit
`ifndef CAN_SIGNAL_PACK_UNPACK_UNIT_ASSERT_SVH
`define CAN_SIGNAL_PACK_UNPACK_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CSPU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cspu assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CSPU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cspu assertion failed");

`endif

// ----- hw/rtl/cspu_pkg.sv -----
// Shared constants, codes and types of the signal packing unit
package cspu_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int MAX_SIGNAL_BITS = 32;
    localparam int BYTE_ADDR_W     = $clog2(MAX_FRAME_BYTES);
    localparam int FB_W            = 7;
    localparam int DIV_W           = 50;
    localparam int MUL_W           = 32;
    localparam int CNT_W           = 6;
    localparam int RES_W           = 64;

    localparam logic [1:0] MODE_WR_BYTE = 2'd0;
    localparam logic [1:0] MODE_RD_BYTE = 2'd1;
    localparam logic [1:0] MODE_PACK    = 2'd2;
    localparam logic [1:0] MODE_UNPACK  = 2'd3;

    localparam logic [47:0] Q48_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] Q48_MIN = 48'h8000_0000_0000;

    typedef struct packed {
        logic go;
        logic div;
    } md_ctl_t;

endpackage

// ----- hw/rtl/cspu_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module cspu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/cspu_muldiv.sv -----
// Iterative divider and multiplier sharing one adder, one bit per cycle
module cspu_muldiv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cspu_pkg::md_ctl_t           ctl,
    input  logic [cspu_pkg::DIV_W-1:0]  opa,
    input  logic [32:0]                 opb,
    output logic                        done,
    output logic [cspu_pkg::RES_W-1:0]  result
);
    import cspu_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [32:0]      rem_reg, rem_next;
    logic [DIV_W-1:0] nq_reg, nq_next;
    logic [32:0]      d_reg, d_next;

    logic [34:0] ax, ay, sum;
    logic [33:0] mb;
    logic        ge;

    always_comb
    begin
        ax  = div_reg ? {1'b0, rem_reg, nq_reg[DIV_W-1]} : {2'b00, rem_reg};
        ay  = div_reg ? ~{2'b00, d_reg} : {2'b00, d_reg};
        sum = ax + ay + {34'd0, div_reg};
        ge  = ~sum[34];
        mb  = nq_reg[0] ? sum[33:0] : {1'b0, rem_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        nq_next   = nq_reg;
        d_next    = d_reg;

        if (ctl.go)
        begin
            busy_next = 1'b1;
            div_next  = ctl.div;
            cnt_next  = ctl.div ? CNT_W'(DIV_W) : CNT_W'(MUL_W);
            rem_next  = '0;
            nq_next   = ctl.div ? opa : DIV_W'(opb[MUL_W-1:0]);
            d_next    = ctl.div ? opb : opa[32:0];
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                rem_next = ge ? sum[32:0] : ax[32:0];
                nq_next  = {nq_reg[DIV_W-2:0], ge};
            end
            else
            begin
                rem_next = mb[33:1];
                nq_next  = {nq_reg[DIV_W-1:MUL_W], mb[0], nq_reg[MUL_W-1:1]};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        d_reg   <= d_next;
    end

    assign done   = done_reg;
    assign result = div_reg ? RES_W'(nq_reg) : {rem_reg[MUL_W-1:0], nq_reg[MUL_W-1:0]};
endmodule

// ----- hw/rtl/can_signal_pack_unpack_unit.sv -----
// Top level: frame byte store, signal pack and unpack sequencer
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  command  | start, busy                | mode, byte_index, byte_in, first_bit,
//           |                            | bit_length, intel_order, signed_raw,
//           |                            | scale_factor, scale_offset, physical_in
//  result   | done (one-cycle strobe)    | status, byte_out, raw_out, physical_out
//  config   | cfg_valid, cfg_ready       | cfg_data (frame_bytes)
//
// Write byte and read byte each make a single RAM access. Pack runs the 50-step
// serial divider and then a read-modify-write per signal bit on the frame RAM;
// unpack reads the signal bits first and then runs the 32-step serial multiplier.
// A bad descriptor ends in the check state. Reset clears the store through per-byte
// valid bits at once; no clearing pass. The result strobe cannot be stalled.
module can_signal_pack_unpack_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [5:0]         byte_index,
    input  logic [7:0]         byte_in,
    input  logic [8:0]         first_bit,
    input  logic [5:0]         bit_length,
    input  logic               intel_order,
    input  logic               signed_raw,
    input  logic signed [31:0] scale_factor,
    input  logic signed [47:0] scale_offset,
    input  logic signed [47:0] physical_in,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data,
    output logic               done,
    output logic               status,
    output logic [7:0]         byte_out,
    output logic signed [32:0] raw_out,
    output logic signed [47:0] physical_out
);
    import cspu_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WR    = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_RDW   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_ABS   = 4'd5;
    localparam logic [3:0] S_DIVGO = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_CLAMP = 4'd8;
    localparam logic [3:0] S_BRD   = 4'd9;
    localparam logic [3:0] S_BMOD  = 4'd10;
    localparam logic [3:0] S_URAW  = 4'd11;
    localparam logic [3:0] S_MULGO = 4'd12;
    localparam logic [3:0] S_MUL   = 4'd13;
    localparam logic [3:0] S_MSAT  = 4'd14;
    localparam logic [3:0] S_ADD   = 4'd15;

    // control
    logic [3:0]                 state_reg, state_next;
    logic                       done_reg, done_next;
    logic [FB_W-1:0]            fb_reg, fb_next;
    logic [MAX_FRAME_BYTES-1:0] vld_reg, vld_next;

    // payload
    logic [1:0]  mode_reg, mode_next;
    logic [5:0]  idx_reg, idx_next;
    logic [7:0]  bin_reg, bin_next;
    logic [8:0]  sb_reg, sb_next;
    logic [5:0]  len_reg, len_next;
    logic        intel_reg, intel_next;
    logic        sgn_reg, sgn_next;
    logic [31:0] fac_reg, fac_next;
    logic [47:0] off_reg, off_next;
    logic [47:0] phys_reg, phys_next;
    logic [48:0] diff_reg, diff_next;
    logic [48:0] ad_reg, ad_next;
    logic        neg_reg, neg_next;
    logic [32:0] raw_reg, raw_next;
    logic [31:0] u_reg, u_next;
    logic [8:0]  pos_reg, pos_next;
    logic [5:0]  k_reg, k_next;
    logic [4:0]  i_reg, i_next;
    logic [51:0] psig_reg, psig_next;
    logic        rvld_reg;
    logic        st_reg, st_next;
    logic [7:0]  bo_reg, bo_next;
    logic [32:0] ro_reg, ro_next;
    logic [47:0] po_reg, po_next;

    // RAM and arithmetic unit
    logic                   ram_we;
    logic [BYTE_ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]             ram_wdata, ram_rdata;
    md_ctl_t                md_ctl;
    logic [DIV_W-1:0]       md_opa;
    logic [32:0]            md_opb;
    logic                   md_done;
    logic [RES_W-1:0]       md_res;

    cspu_ram #(.WIDTH(8), .DEPTH(MAX_FRAME_BYTES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cspu_muldiv u_md (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (md_ctl),
        .opa    (md_opa),
        .opb    (md_opb),
        .done   (md_done),
        .result (md_res)
    );

    logic        accept;
    logic [7:0]  rbyte;
    logic [9:0]  fbits;
    logic [5:0]  off8, remb;
    logic [6:0]  lastb;
    logic        bad;
    logic [31:0] af;
    logic [32:0] absraw;
    logic [40:0] qs;
    logic [41:0] rawq, hi, lo, rawc;
    logic [32:0] ext;
    logic [50:0] pm;
    logic [52:0] sum53;
    logic [8:0]  mstep;
    logic        lastbit;
    logic [7:0]  bmask;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rbyte     = rvld_reg ? ram_rdata : 8'd0;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        fb_next    = fb_reg;
        vld_next   = vld_reg;
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        bin_next   = bin_reg;
        sb_next    = sb_reg;
        len_next   = len_reg;
        intel_next = intel_reg;
        sgn_next   = sgn_reg;
        fac_next   = fac_reg;
        off_next   = off_reg;
        phys_next  = phys_reg;
        diff_next  = diff_reg;
        ad_next    = ad_reg;
        neg_next   = neg_reg;
        raw_next   = raw_reg;
        u_next     = u_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        psig_next  = psig_reg;
        st_next    = st_reg;
        bo_next    = bo_reg;
        ro_next    = ro_reg;
        po_next    = po_reg;

        ram_we    = 1'b0;
        ram_waddr = pos_reg[8:3];
        ram_wdata = 8'd0;
        ram_raddr = pos_reg[8:3];
        md_ctl    = '0;
        md_opa    = '0;
        md_opb    = '0;

        af     = fac_reg[31] ? (~fac_reg + 32'd1) : fac_reg;
        absraw = raw_reg[32] ? (~raw_reg + 33'd1) : raw_reg;

        // descriptor check
        fbits = {fb_reg, 3'b000};
        off8  = {3'b000, sb_reg[2:0]};
        remb  = len_reg - off8 - 6'd1;
        lastb = {1'b0, sb_reg[8:3]} + (({1'b0, remb} + 7'd7) >> 3);
        bad   = (fb_reg == '0) || (fb_reg > FB_W'(MAX_FRAME_BYTES))
             || (len_reg == 6'd0) || (len_reg > 6'(MAX_SIGNAL_BITS))
             || (fac_reg == 32'd0) || ({1'b0, sb_reg} >= fbits);
        if (intel_reg)
        begin
            bad = bad || (({1'b0, sb_reg} + {4'd0, len_reg}) > fbits);
        end
        else if (len_reg > off8 + 6'd1)
        begin
            bad = bad || (lastb >= fb_reg);
        end

        // pack clamp
        qs   = (md_res[DIV_W-1:0] > DIV_W'(64'd1 << 40)) ? 41'h100_0000_0000
                                                           : md_res[40:0];
        rawq = neg_reg ? (~{1'b0, qs} + 42'd1) : {1'b0, qs};
        if (sgn_reg)
        begin
            hi = (42'd1 << (len_reg - 6'd1)) - 42'd1;
            lo = ~(42'd1 << (len_reg - 6'd1)) + 42'd1;
        end
        else
        begin
            hi = (42'd1 << len_reg) - 42'd1;
            lo = '0;
        end
        if ($signed(rawq) < $signed(lo))
        begin
            rawc = lo;
        end
        else if ($signed(rawq) > $signed(hi))
        begin
            rawc = hi;
        end
        else
        begin
            rawc = rawq;
        end

        // unpack sign extension
        ext = {1'b0, u_reg};
        if (sgn_reg && u_reg[5'(len_reg - 6'd1)])
        begin
            ext = ext | ~((33'd1 << len_reg) - 33'd1);
        end

        // product limit and offset
        pm    = (md_res > (RES_W'(1) << 50)) ? (51'd1 << 50) : md_res[50:0];
        sum53 = {psig_reg[51], psig_reg} + {{5{off_reg[47]}}, off_reg};

        mstep   = (pos_reg[2:0] == 3'd0) ? (pos_reg + 9'd15) : (pos_reg - 9'd1);
        lastbit = (k_reg == len_reg - 6'd1);
        bmask   = 8'd1 << pos_reg[2:0];

        if (cfg_valid)
        begin
            fb_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = mode;
                    idx_next   = byte_index;
                    bin_next   = byte_in;
                    sb_next    = first_bit;
                    len_next   = bit_length;
                    intel_next = intel_order;
                    sgn_next   = signed_raw;
                    fac_next   = scale_factor;
                    off_next   = scale_offset;
                    phys_next  = physical_in;
                    case (mode)
                        MODE_WR_BYTE: state_next = S_WR;
                        MODE_RD_BYTE: state_next = S_RD;
                        default:      state_next = S_CHK;
                    endcase
                end
            end
            S_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = bin_reg;
                vld_next[idx_reg] = 1'b1;
                st_next    = 1'b0;
                bo_next    = 8'd0;
                ro_next    = '0;
                po_next    = '0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = S_RDW;
            end
            S_RDW:
            begin
                st_next    = 1'b0;
                bo_next    = rbyte;
                ro_next    = '0;
                po_next    = '0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_CHK:
            begin
                diff_next = {phys_reg[47], phys_reg} - {off_reg[47], off_reg};
                pos_next  = sb_reg;
                k_next    = 6'd0;
                i_next    = intel_reg ? 5'd0 : 5'(len_reg - 6'd1);
                u_next    = '0;
                if (bad)
                begin
                    st_next    = 1'b1;
                    bo_next    = 8'd0;
                    ro_next    = '0;
                    po_next    = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (mode_reg == MODE_PACK)
                begin
                    state_next = S_ABS;
                end
                else
                begin
                    state_next = S_BRD;
                end
            end
            S_ABS:
            begin
                ad_next    = diff_reg[48] ? (~diff_reg + 49'd1) : diff_reg;
                neg_next   = diff_reg[48] ^ fac_reg[31];
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                // (2|d| + |f|) / 2|f| gives the half-away rounding
                md_ctl.go  = 1'b1;
                md_ctl.div = 1'b1;
                md_opa     = {ad_reg, 1'b0} + DIV_W'(af);
                md_opb     = {af, 1'b0};
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (md_done)
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                raw_next   = rawc[32:0];
                state_next = S_BRD;
            end
            S_BRD:
            begin
                state_next = S_BMOD;
            end
            S_BMOD:
            begin
                if (mode_reg == MODE_PACK)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = (rbyte & ~bmask) | (raw_reg[i_reg] ? bmask : 8'd0);
                    vld_next[pos_reg[8:3]] = 1'b1;
                end
                else
                begin
                    u_next[i_reg] = rbyte[pos_reg[2:0]];
                end
                k_next   = k_reg + 6'd1;
                pos_next = intel_reg ? (pos_reg + 9'd1) : mstep;
                i_next   = intel_reg ? (i_reg + 5'd1) : (i_reg - 5'd1);
                if (!lastbit)
                begin
                    state_next = S_BRD;
                end
                else if (mode_reg == MODE_PACK)
                begin
                    st_next    = 1'b0;
                    bo_next    = 8'd0;
                    ro_next    = raw_reg;
                    po_next    = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_URAW;
                end
            end
            S_URAW:
            begin
                raw_next   = ext;
                state_next = S_MULGO;
            end
            S_MULGO:
            begin
                md_ctl.go  = 1'b1;
                md_ctl.div = 1'b0;
                md_opa     = DIV_W'(absraw);
                md_opb     = {1'b0, af};
                neg_next   = raw_reg[32] ^ fac_reg[31];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (md_done)
                begin
                    state_next = S_MSAT;
                end
            end
            S_MSAT:
            begin
                psig_next  = neg_reg ? (~{1'b0, pm} + 52'd1) : {1'b0, pm};
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if ($signed(sum53) > $signed(53'($signed(Q48_MAX))))
                begin
                    po_next = Q48_MAX;
                end
                else if ($signed(sum53) < $signed(53'($signed(Q48_MIN))))
                begin
                    po_next = Q48_MIN;
                end
                else
                begin
                    po_next = sum53[47:0];
                end
                st_next    = 1'b0;
                bo_next    = 8'd0;
                ro_next    = raw_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            fb_reg    <= FB_W'(8);
            vld_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            fb_reg    <= fb_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        idx_reg   <= idx_next;
        bin_reg   <= bin_next;
        sb_reg    <= sb_next;
        len_reg   <= len_next;
        intel_reg <= intel_next;
        sgn_reg   <= sgn_next;
        fac_reg   <= fac_next;
        off_reg   <= off_next;
        phys_reg  <= phys_next;
        diff_reg  <= diff_next;
        ad_reg    <= ad_next;
        neg_reg   <= neg_next;
        raw_reg   <= raw_next;
        u_reg     <= u_next;
        pos_reg   <= pos_next;
        k_reg     <= k_next;
        i_reg     <= i_next;
        psig_reg  <= psig_next;
        rvld_reg  <= vld_reg[ram_raddr];
        st_reg    <= st_next;
        bo_reg    <= bo_next;
        ro_reg    <= ro_next;
        po_reg    <= po_next;
    end

    assign done         = done_reg;
    assign status       = st_reg;
    assign byte_out     = bo_reg;
    assign raw_out      = ro_reg;
    assign physical_out = po_reg;
endmodule

// ----- hw/rtl/cspu_chk.sv -----
// Port-level checker of the signal packing unit and its bind
`include "can_signal_pack_unpack_unit_assert.svh"

module cspu_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               status,
    input logic [7:0]         byte_out,
    input logic signed [32:0] raw_out,
    input logic signed [47:0] physical_out
);
    logic zero_out;

    assign zero_out = (byte_out == 8'd0) && (raw_out == 33'sd0) && (physical_out == 48'sd0);

    `CSPU_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `CSPU_ASSERT_NOW(a_done_idle, done, !busy)
    `CSPU_ASSERT_NEXT(a_done_pulse, done, !done)
    `CSPU_ASSERT_NOW(a_err_zero, done && status, zero_out)
endmodule

bind can_signal_pack_unpack_unit cspu_chk u_cspu_chk (.*);
